// ===== src/sbgs_pkg.sv =====
`timescale 1ns / 1ps
// sbgs_pkg: shared types and constants of the sparse basis gradient scorer
// no dependencies

package sbgs_pkg;

    localparam int FEAT_W  = 16;
    localparam int VAL_W   = 24;
    localparam int SUM_W   = 25;
    localparam int WGT_W   = 17;
    localparam int IDX_W   = 10;
    localparam int SCORE_W = 64;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic signed [VAL_W-1:0] MARGIN_ONE = 24'sd65536;

    typedef struct packed {
        logic [FEAT_W-1:0]        feature_a;
        logic [FEAT_W-1:0]        feature_b;
        logic                     basis_negative;
        logic signed [VAL_W-1:0]  basis_coef;
        logic signed [VAL_W-1:0]  margin;
        logic signed [VAL_W-1:0]  x_a;
        logic signed [VAL_W-1:0]  x_b;
        logic signed [VAL_W-1:0]  yz_a;
        logic signed [VAL_W-1:0]  yz_b;
        logic                     has_term;
        logic                     end_of_basis;
        logic                     end_of_all;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]           min_basis_index;
        logic [IDX_W-1:0]           max_basis_index;
        logic [FEAT_W-1:0]          min_feature_low;
        logic [FEAT_W-1:0]          min_feature_high;
        logic                       min_negative;
        logic [FEAT_W-1:0]          max_feature_low;
        logic [FEAT_W-1:0]          max_feature_high;
        logic                       max_negative;
        logic signed [SCORE_W-1:0]  min_score;
        logic signed [SCORE_W-1:0]  max_score;
        logic signed [SCORE_W-1:0]  total_gradient;
        logic                       zero_grad_error;
    } out_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [FEAT_W-1:0]        feat_lo;
        logic [FEAT_W-1:0]        feat_hi;
        logic                     neg;
        logic                     counted;
        logic signed [SUM_W-1:0]  sum_x;
        logic signed [SUM_W-1:0]  sum_y;
        logic [WGT_W-1:0]         weight;
        logic signed [VAL_W-1:0]  coef;
        logic                     close;
        logic                     last;
    } term_t;

endpackage

// ===== src/sparse_basis_gradient_scorer_top.sv =====
`timescale 1ns / 1ps
// sparse_basis_gradient_scorer_top: front classifier, term queue and back sequencer
// depends on sbgs_pkg, sbgs_front, sbgs_queue, sbgs_back

// Requests enter a two-entry queue; the back end then works through them one at a
// time. A counted term steps through fetch, five passes through one shared 26x26
// multiplier and the accumulate; a request that only carries markers needs just the
// fetch, closing a basis adds a close step and the end of a pass adds an emit step
// to load the result register, which can wait there while work continues.
// The shared multiplier sets the term rate. After a result the scorer starts the
// next pass from its reset state.

module sparse_basis_gradient_scorer_top #(
    parameter int MAX_BASES          = 1024,
    parameter int FEATURE_INDEX_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  sbgs_pkg::in_t  item,
    output logic           empty,
    input  logic           pop,
    output sbgs_pkg::out_t result
);

    sbgs_pkg::term_t front_term;
    sbgs_pkg::term_t q_data;
    logic            q_empty;
    logic            q_pop;

    sbgs_front #(
        .FEATURE_INDEX_BITS (FEATURE_INDEX_BITS)
    ) u_front (
        .item (item),
        .term (front_term)
    );

    sbgs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_term),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_data),
        .empty (q_empty)
    );

    sbgs_back #(
        .MAX_BASES (MAX_BASES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// ===== src/sbgs_front.sv =====
`timescale 1ns / 1ps
// sbgs_front: classifies an incoming request into a term for the back end
// depends on sbgs_pkg

module sbgs_front #(
    parameter int FEATURE_INDEX_BITS = 16
) (
    input  sbgs_pkg::in_t   item,
    output sbgs_pkg::term_t term
);

    localparam logic [sbgs_pkg::FEAT_W-1:0] FEAT_MASK =
        (FEATURE_INDEX_BITS >= sbgs_pkg::FEAT_W) ? '1 :
        sbgs_pkg::FEAT_W'((64'd1 << FEATURE_INDEX_BITS) - 64'd1);

    logic [sbgs_pkg::FEAT_W-1:0] fa;
    logic [sbgs_pkg::FEAT_W-1:0] fb;

    always_comb
    begin
        fa = item.feature_a & FEAT_MASK;
        fb = item.feature_b & FEAT_MASK;

        term.feat_lo = (fa <= fb) ? fa : fb;
        term.feat_hi = (fa <= fb) ? fb : fa;
        term.neg     = item.basis_negative;
        term.counted = item.has_term && (item.margin < sbgs_pkg::MARGIN_ONE);

        // inner sum factors as (xa +/- xb) * (ya +/- yb)
        if (item.basis_negative)
        begin
            term.sum_x = {item.x_a[23], item.x_a} - {item.x_b[23], item.x_b};
            term.sum_y = {item.yz_a[23], item.yz_a} - {item.yz_b[23], item.yz_b};
        end
        else
        begin
            term.sum_x = {item.x_a[23], item.x_a} + {item.x_b[23], item.x_b};
            term.sum_y = {item.yz_a[23], item.yz_a} + {item.yz_b[23], item.yz_b};
        end

        if (item.margin[sbgs_pkg::VAL_W-1])
            term.weight = sbgs_pkg::WEIGHT_ONE;
        else
            term.weight = sbgs_pkg::WEIGHT_ONE - {1'b0, item.margin[15:0]};

        term.coef  = item.basis_coef;
        term.close = item.end_of_basis | item.end_of_all;
        term.last  = item.end_of_all;
    end

endmodule

// ===== src/sbgs_queue.sv =====
`timescale 1ns / 1ps
// sbgs_queue: two-entry queue of classified terms between front and back
// depends on sbgs_pkg

module sbgs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sbgs_pkg::term_t wdata,
    output logic            full,
    input  logic            pop,
    output sbgs_pkg::term_t rdata,
    output logic            empty
);

    sbgs_pkg::term_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== src/sbgs_back.sv =====
`timescale 1ns / 1ps
// sbgs_back: sequencer over one shared multiplier, accumulators, min/max tracking
// and the result holding register; depends on sbgs_pkg

module sbgs_back #(
    parameter int MAX_BASES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sbgs_pkg::term_t q_data,
    input  logic            q_empty,
    output logic            q_pop,
    output sbgs_pkg::out_t  result,
    output logic            empty,
    input  logic            pop
);

    localparam int CNT_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BASES - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_INNER,
        ST_MUL_WLO,
        ST_MUL_WHI,
        ST_MUL_CLO,
        ST_MUL_CHI,
        ST_ACCUM,
        ST_CLOSE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]            index;
        logic [sbgs_pkg::FEAT_W-1:0] feat_lo;
        logic [sbgs_pkg::FEAT_W-1:0] feat_hi;
        logic                        neg;
    } info_t;

    state_t                 state_reg;
    logic signed [63:0]     score_reg;
    logic signed [63:0]     low_score_reg;
    logic signed [63:0]     high_score_reg;
    info_t                  low_info_reg;
    info_t                  high_info_reg;
    logic signed [63:0]     total_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   err_reg;
    logic                   first_reg;
    logic                   out_valid_reg;

    sbgs_pkg::term_t        term_reg;
    logic signed [49:0]     inner_reg;
    logic [66:0]            gacc_reg;
    logic [74:0]            cacc_reg;
    sbgs_pkg::out_t         result_reg;

    logic signed [25:0]     mul_a;
    logic signed [25:0]     mul_b;
    logic signed [51:0]     mul_p;
    logic [50:0]            grad;
    logic [58:0]            gcoef;
    logic signed [63:0]     score_sum;
    logic signed [63:0]     total_sum;
    info_t                  cur_info;
    logic                   emit_fire;
    logic [CNT_W+9:0]       low_idx_ext;
    logic [CNT_W+9:0]       high_idx_ext;

    function automatic logic signed [63:0] sat_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63])
            sat_add = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            sat_add = sum[63:0];
    endfunction

    assign grad  = gacc_reg[66:16];
    assign gcoef = cacc_reg[74:16];
    assign mul_p = mul_a * mul_b;

    assign score_sum = sat_add(score_reg, {{13{grad[50]}}, grad});
    assign total_sum = sat_add(total_reg, {{5{gcoef[58]}}, gcoef});

    assign cur_info.index   = cnt_reg;
    assign cur_info.feat_lo = term_reg.feat_lo;
    assign cur_info.feat_hi = term_reg.feat_hi;
    assign cur_info.neg     = term_reg.neg;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || pop);
    assign empty     = !out_valid_reg;
    assign result    = result_reg;

    assign low_idx_ext  = {10'd0, low_info_reg.index};
    assign high_idx_ext = {10'd0, high_info_reg.index};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_INNER:
            begin
                mul_a = {term_reg.sum_x[24], term_reg.sum_x};
                mul_b = {term_reg.sum_y[24], term_reg.sum_y};
            end
            ST_MUL_WLO:
            begin
                mul_a = {1'b0, inner_reg[24:0]};
                mul_b = {9'd0, term_reg.weight};
            end
            ST_MUL_WHI:
            begin
                mul_a = {inner_reg[49], inner_reg[49:25]};
                mul_b = {9'd0, term_reg.weight};
            end
            ST_MUL_CLO:
            begin
                mul_a = {1'b0, grad[24:0]};
                mul_b = {{2{term_reg.coef[23]}}, term_reg.coef};
            end
            ST_MUL_CHI:
            begin
                mul_a = $signed(grad[50:25]);
                mul_b = {{2{term_reg.coef[23]}}, term_reg.coef};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            score_reg      <= '0;
            low_score_reg  <= '0;
            high_score_reg <= '0;
            low_info_reg   <= '0;
            high_info_reg  <= '0;
            total_reg      <= '0;
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
            first_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (q_data.counted)
                            state_reg <= ST_MUL_INNER;
                        else if (q_data.close)
                            state_reg <= ST_CLOSE;
                    end
                end
                ST_MUL_INNER: state_reg <= ST_MUL_WLO;
                ST_MUL_WLO:   state_reg <= ST_MUL_WHI;
                ST_MUL_WHI:   state_reg <= ST_MUL_CLO;
                ST_MUL_CLO:   state_reg <= ST_MUL_CHI;
                ST_MUL_CHI:   state_reg <= ST_ACCUM;
                ST_ACCUM:
                begin
                    score_reg <= score_sum;
                    total_reg <= total_sum;
                    if (inner_reg == '0)
                        err_reg <= 1'b1;
                    state_reg <= term_reg.close ? ST_CLOSE : ST_IDLE;
                end
                ST_CLOSE:
                begin
                    if (first_reg || (score_reg < low_score_reg))
                    begin
                        low_score_reg <= score_reg;
                        low_info_reg  <= cur_info;
                    end
                    if (first_reg || (score_reg > high_score_reg))
                    begin
                        high_score_reg <= score_reg;
                        high_info_reg  <= cur_info;
                    end
                    first_reg <= 1'b0;
                    score_reg <= '0;
                    cnt_reg   <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
                    state_reg <= term_reg.last ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (emit_fire)
                    begin
                        score_reg      <= '0;
                        low_score_reg  <= '0;
                        high_score_reg <= '0;
                        low_info_reg   <= '0;
                        high_info_reg  <= '0;
                        total_reg      <= '0;
                        cnt_reg        <= '0;
                        err_reg        <= 1'b0;
                        first_reg      <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            term_reg <= q_data;
        if (state_reg == ST_MUL_INNER)
            inner_reg <= mul_p[49:0];
        if (state_reg == ST_MUL_WLO)
            gacc_reg <= {{15{mul_p[51]}}, mul_p};
        if (state_reg == ST_MUL_WHI)
            gacc_reg <= gacc_reg + {mul_p[41:0], 25'd0};
        if (state_reg == ST_MUL_CLO)
            cacc_reg <= {{23{mul_p[51]}}, mul_p};
        if (state_reg == ST_MUL_CHI)
            cacc_reg <= cacc_reg + {mul_p[49:0], 25'd0};
        if (emit_fire)
        begin
            result_reg.min_basis_index  <= low_idx_ext[9:0];
            result_reg.max_basis_index  <= high_idx_ext[9:0];
            result_reg.min_feature_low  <= low_info_reg.feat_lo;
            result_reg.min_feature_high <= low_info_reg.feat_hi;
            result_reg.min_negative     <= low_info_reg.neg;
            result_reg.max_feature_low  <= high_info_reg.feat_lo;
            result_reg.max_feature_high <= high_info_reg.feat_hi;
            result_reg.max_negative     <= high_info_reg.neg;
            result_reg.min_score        <= low_score_reg;
            result_reg.max_score        <= high_score_reg;
            result_reg.total_gradient   <= total_reg;
            result_reg.zero_grad_error  <= err_reg;
        end
    end

endmodule
